// ----- hw/rtl/scrolling_text_column_renderer_macros.svh -----
// Assertion macros used by the checker.
`ifndef SCROLLING_TEXT_COLUMN_RENDERER_MACROS_SVH
`define SCROLLING_TEXT_COLUMN_RENDERER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define STCR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define STCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- hw/rtl/stcr_pkg.sv -----
// ----------------------------------------------------------------------------
// stcr_pkg
// Types, constants and font tables of the scrolling text column renderer.
// ----------------------------------------------------------------------------
package stcr_pkg;
   localparam int MAX_CHARS_DEF  = 64;
   localparam int PANEL_SIZE_DEF = 16;
   localparam logic [8:0] SCROLL_RESET = 9'd200;
   localparam logic [5:0] SPACE_GLYPH  = 6'd63;

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_COMMIT = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_RENDER = 2'd3
   } req_kind_type;

   localparam logic CSR_SPACING  = 1'b0;
   localparam logic CSR_INTERVAL = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_C_RD,     // read char store entry
      ST_C_WAIT,
      ST_C_PROC,   // classify and write glyph
      ST_C_DONE,
      ST_R_SCROLL,
      ST_R_COL,    // start a column search
      ST_R_RD,     // read glyph i
      ST_R_WAIT,
      ST_R_TEST,
      ST_R_CRD,    // read color of the owning glyph
      ST_R_CWAIT,
      ST_R_OUT
   } state_type;

   // Width 0 marks an unsupported code.
   function automatic logic [2:0] font_width(input logic [5:0] f);
      logic [2:0] w;
      case (f)
         6'd10, 6'd11, 6'd12, 6'd13, 6'd16, 6'd17, 6'd20, 6'd24, 6'd30: w = 3'd4;
         6'd22, 6'd23, 6'd26, 6'd31, 6'd32, 6'd33, 6'd35:               w = 3'd5;
         default: w = (f < 6'd36) ? 3'd3 : 3'd0;
      endcase
      return w;
   endfunction

   function automatic logic [79:0] font_row(input logic [5:0] f);
      logic [79:0] r;
      case (f)
         6'd0:  r = {16'h0,16'h0,16'h7FFE,16'h6006,16'h7FFE};
         6'd1:  r = {16'h0,16'h0,16'h6000,16'h7FFE,16'h6018};
         6'd2:  r = {16'h0,16'h0,16'h61FE,16'h6186,16'h7F86};
         6'd3:  r = {16'h0,16'h0,16'h7FFE,16'h6186,16'h6186};
         6'd4:  r = {16'h0,16'h0,16'h7FFE,16'h0180,16'h01FE};
         6'd5:  r = {16'h0,16'h0,16'h7F86,16'h6186,16'h61FE};
         6'd6:  r = {16'h0,16'h0,16'h7F86,16'h6186,16'h7FFE};
         6'd7:  r = {16'h0,16'h0,16'h7FFE,16'h0006,16'h0006};
         6'd8:  r = {16'h0,16'h0,16'h7FFE,16'h6186,16'h7FFE};
         6'd9:  r = {16'h0,16'h0,16'h7FFE,16'h0186,16'h01FE};
         6'd10: r = {16'h0,16'h7FF8,16'h00C6,16'h00C6,16'h7FF8};
         6'd11: r = {16'h0,16'h1F38,16'h60C6,16'h60C6,16'h7FFE};
         6'd12: r = {16'h0,16'h381C,16'h6006,16'h6006,16'h3FFC};
         6'd13: r = {16'h0,16'h1FF8,16'h6006,16'h6006,16'h7FFE};
         6'd14: r = {16'h0,16'h0,16'h6186,16'h6186,16'h7FFE};
         6'd15: r = {16'h0,16'h0,16'h0186,16'h0186,16'h7FFE};
         6'd16: r = {16'h0,16'h7F1C,16'h6306,16'h6006,16'h3FFC};
         6'd17: r = {16'h0,16'h7FFE,16'h0180,16'h0180,16'h7FFE};
         6'd18: r = {16'h0,16'h0,16'h6006,16'h7FFE,16'h6006};
         6'd19: r = {16'h0,16'h0,16'h3FFE,16'h6000,16'h3C00};
         6'd20: r = {16'h0,16'h781E,16'h0E70,16'h03C0,16'h7FFE};
         6'd21: r = {16'h0,16'h0,16'h6000,16'h6000,16'h7FFE};
         6'd22: r = {16'h7FFE,16'h0038,16'h00E0,16'h0038,16'h7FFE};
         6'd23: r = {16'h7FFE,16'h1E00,16'h03C0,16'h0078,16'h7FFE};
         6'd24: r = {16'h0,16'h1FF8,16'h6006,16'h6006,16'h1FF8};
         6'd25: r = {16'h0,16'h0,16'h00FC,16'h0186,16'h7FFE};
         6'd26: r = {16'h6000,16'h1FF8,16'h6606,16'h6006,16'h1FF8};
         6'd27: r = {16'h0,16'h0,16'h7EFC,16'h0186,16'h7FFE};
         6'd28: r = {16'h0,16'h0,16'h3F0C,16'h6186,16'h30FC};
         6'd29: r = {16'h0,16'h0,16'h0006,16'h7FFE,16'h0006};
         6'd30: r = {16'h0,16'h1FFE,16'h6000,16'h6000,16'h1FFE};
         6'd31: r = {16'h07FE,16'h1800,16'h7000,16'h1800,16'h07FE};
         6'd32: r = {16'h7FFE,16'h1C00,16'h0700,16'h1C00,16'h7FFE};
         6'd33: r = {16'h781E,16'h0F78,16'h03E0,16'h0F78,16'h781E};
         6'd34: r = {16'h0,16'h0,16'h007E,16'h7F80,16'h007E};
         6'd35: r = {16'h600E,16'h6076,16'h6186,16'h6E06,16'h7006};
         default: r = '0;
      endcase
      return r;
   endfunction

   // Maps an ASCII code to a font index; returns SPACE_GLYPH for space and
   // 6'd62 for a dropped code.
   function automatic logic [5:0] char_to_font(input logic [7:0] ch);
      logic [7:0] c;
      logic [5:0] f;
      c = ch;
      if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
      if (c >= 8'h30 && c <= 8'h39)      f = 6'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h5A) f = 6'(c - 8'h41 + 8'd10);
      else if (c == 8'h20)               f = SPACE_GLYPH;
      else                               f = 6'd62;
      return f;
   endfunction
endpackage

// ----- hw/rtl/stcr_if.sv -----
// ----------------------------------------------------------------------------
// stcr_if
// Valid/ready channel interfaces for requests, responses and registers.
// ----------------------------------------------------------------------------
interface stcr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [5:0] position;
   logic [7:0] char_code;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [6:0] text_length;
   modport source (output valid, req_type, position, char_code, red, green, blue,
                   text_length, input ready);
   modport sink (input valid, req_type, position, char_code, red, green, blue,
                 text_length, output ready);
endinterface

interface stcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] column_bits;
   logic [3:0]  column_index;
   logic [7:0]  pixel_red;
   logic [7:0]  pixel_green;
   logic [7:0]  pixel_blue;
   logic        is_last;
   logic [6:0]  glyph_total;
   logic        scrolling;
   modport source (output valid, column_bits, column_index, pixel_red, pixel_green,
                   pixel_blue, is_last, glyph_total, scrolling, input ready);
   modport sink (input valid, column_bits, column_index, pixel_red, pixel_green,
                 pixel_blue, is_last, glyph_total, scrolling, output ready);
endinterface

interface stcr_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [8:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/stcr_ram.sv -----
// ----------------------------------------------------------------------------
// stcr_ram
// Generic RAM with one write port, one read port and a registered read.
// ----------------------------------------------------------------------------
module stcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule

// ----- hw/rtl/stcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// stcr_ctrl
// Sequencer for commit layout and column render.
// ----------------------------------------------------------------------------
module stcr_ctrl #(
   parameter int MAX_CHARS  = stcr_pkg::MAX_CHARS_DEF,
   parameter int PANEL_SIZE = stcr_pkg::PANEL_SIZE_DEF
) (
   input  logic clock,
   input  logic reset,
   stcr_req_if.sink   req,
   stcr_rsp_if.source rsp,
   stcr_csr_if.sink   csr
);
   import stcr_pkg::*;
   localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

   state_type state_ff, state_in;
   logic        spacing_ff;
   logic [8:0]  interval_ff;
   logic [6:0]  count_ff, count_in;
   logic [8:0]  width_ff, width_in;
   logic signed [9:0] offset_ff, offset_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [6:0]  len_ff, len_in;
   logic [6:0]  i_ff, i_in;      // char index during commit, glyph index during render
   logic [6:0]  n_ff, n_in;
   logic [8:0]  cursor_ff, cursor_in;
   logic [4:0]  col_ff, col_in;
   logic [15:0] bits_ff, bits_in;
   logic [5:0]  srcpos_ff, srcpos_in;

   logic        rsp_valid_ff;

   // Stores.
   logic        cs_we;
   logic [AW-1:0] cs_waddr, cs_raddr;
   logic [31:0] cs_wdata, cs_rdata;
   logic        gl_we;
   logic [AW-1:0] gl_waddr, gl_raddr;
   logic [23:0] gl_wdata, gl_rdata;

   stcr_ram #(.WIDTH(32), .DEPTH(MAX_CHARS)) u_chars (
      .clock(clock), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
      .raddr(cs_raddr), .rdata(cs_rdata));
   stcr_ram #(.WIDTH(24), .DEPTH(MAX_CHARS)) u_glyphs (
      .clock(clock), .we(gl_we), .waddr(gl_waddr), .wdata(gl_wdata),
      .raddr(gl_raddr), .rdata(gl_rdata));

   logic req_fire, rsp_fire;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign csr.ready = 1'b1;

   // Decode of fetched character and glyph.
   logic [5:0] cur_font;
   logic [2:0] cur_w;
   logic [5:0] g_font, g_src;
   logic [8:0] g_start;
   logic [2:0] g_w;
   logic signed [10:0] x_s, rel;
   logic [79:0] frow;
   assign cur_font = char_to_font(cs_rdata[7:0]);
   assign cur_w = (cur_font == SPACE_GLYPH) ? (spacing_ff ? 3'd2 : 3'd1)
                                             : font_width(cur_font);
   assign {g_font, g_src, g_start, g_w} = gl_rdata;
   assign x_s  = 11'($signed({6'd0, col_ff})) - 11'(offset_ff);
   assign rel  = x_s - $signed({2'b0, g_start});
   assign frow = font_row(g_font);

   logic [6:0] len_sat;
   assign len_sat = (req.text_length > 7'(MAX_CHARS)) ? 7'(MAX_CHARS) : req.text_length;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) begin
            case (req.req_type)
               REQ_COMMIT: state_in = ST_C_RD;
               REQ_RENDER: state_in = ST_R_SCROLL;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_C_RD:    state_in = (i_ff < len_ff) ? ST_C_WAIT : ST_C_DONE;
         ST_C_WAIT:  state_in = ST_C_PROC;
         ST_C_PROC:  state_in = ST_C_RD;
         ST_C_DONE:  state_in = ST_IDLE;
         ST_R_SCROLL: state_in = ST_R_COL;
         ST_R_COL:   state_in = ST_R_RD;
         ST_R_RD:    state_in = (i_ff < count_ff) ? ST_R_WAIT : ST_R_OUT;
         ST_R_WAIT:  state_in = ST_R_TEST;
         ST_R_TEST: begin
            if (rel >= 0 && rel < $signed({8'd0, g_w})) state_in = ST_R_CRD;
            else state_in = ST_R_RD;
         end
         ST_R_CRD:   state_in = ST_R_CWAIT;
         ST_R_CWAIT: state_in = ST_R_OUT;
         ST_R_OUT:   if (rsp_fire)
            state_in = (col_ff == 5'(PANEL_SIZE - 1)) ? ST_IDLE : ST_R_COL;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff; width_in = width_ff; offset_in = offset_ff;
      elapsed_in = elapsed_ff; len_in = len_ff; i_in = i_ff; n_in = n_ff;
      cursor_in = cursor_ff; col_in = col_ff; bits_in = bits_ff; srcpos_in = srcpos_ff;
      cs_we = 1'b0; cs_waddr = req.position[AW-1:0];
      cs_wdata = {req.blue, req.green, req.red, req.char_code};
      cs_raddr = i_ff[AW-1:0];
      gl_we = 1'b0; gl_waddr = n_ff[AW-1:0];
      gl_wdata = {cur_font, 6'(i_ff), cursor_ff, cur_w};
      gl_raddr = i_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: if (req_fire) begin
            case (req.req_type)
               REQ_WRITE: cs_we = ({1'b0, req.position} < 7'(MAX_CHARS));
               REQ_COMMIT: begin
                  len_in = len_sat; i_in = '0; n_in = '0; cursor_in = '0;
               end
               REQ_TICK: if (elapsed_ff != 16'hFFFF) elapsed_in = elapsed_ff + 16'd1;
               default: col_in = '0;
            endcase
         end
         ST_C_PROC: begin
            if (cur_w != 3'd0) begin
               gl_we = 1'b1;
               n_in = n_ff + 7'd1;
               cursor_in = cursor_ff + 9'(cur_w)
                         + 9'(spacing_ff && (i_ff + 7'd1 < len_ff));
            end
            i_in = i_ff + 7'd1;
         end
         ST_C_DONE: begin
            count_in = n_ff; width_in = cursor_ff; elapsed_in = '0;
            offset_in = (cursor_ff > 9'(PANEL_SIZE)) ? 10'sd16
                      : 10'((9'(PANEL_SIZE) - cursor_ff) >> 1);
         end
         ST_R_SCROLL: if (width_ff > 9'(PANEL_SIZE) && elapsed_ff >= {7'd0, interval_ff}) begin
            elapsed_in = '0;
            if ((offset_ff - 10'sd1) <= -$signed({1'b0, width_ff}))
               offset_in = 10'(PANEL_SIZE);
            else offset_in = offset_ff - 10'sd1;
         end
         ST_R_COL: begin i_in = '0; bits_in = '0; end
         // The glyph address holds through the read and the test, so the
         // index only moves on once the fetched entry has been compared.
         ST_R_TEST: begin
            i_in = i_ff + 7'd1;
            if (rel >= 0 && rel < $signed({8'd0, g_w})) begin
               bits_in = (g_font < 6'd36 && rel < 5) ? frow[16*rel[2:0] +: 16] : 16'd0;
               srcpos_in = g_src;
            end
         end
         ST_R_CRD: cs_raddr = srcpos_ff[AW-1:0];
         ST_R_OUT: if (rsp_fire) col_in = col_ff + 5'd1;
         default: ;
      endcase
   end

   logic [23:0] color_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; spacing_ff <= 1'b0; interval_ff <= SCROLL_RESET;
         count_ff <= '0; width_ff <= '0; offset_ff <= '0; elapsed_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; width_ff <= width_in;
         offset_ff <= offset_in; elapsed_ff <= elapsed_in;
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_SPACING) spacing_ff <= csr.data[0];
            else interval_ff <= csr.data;
         end
         if (rsp_fire) rsp_valid_ff <= 1'b0;
         else if (state_in == ST_R_OUT && state_ff != ST_R_OUT) rsp_valid_ff <= 1'b1;
      end
      len_ff <= len_in; i_ff <= i_in; n_ff <= n_in; cursor_ff <= cursor_in;
      col_ff <= col_in; bits_ff <= bits_in; srcpos_ff <= srcpos_in;
      if (state_ff == ST_R_COL) color_ff <= '0;
      else if (state_ff == ST_R_CWAIT && bits_ff != 16'd0) color_ff <= cs_rdata[31:8];
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.column_bits  = bits_ff;
   assign rsp.column_index = col_ff[3:0];
   assign rsp.pixel_red    = color_ff[7:0];
   assign rsp.pixel_green  = color_ff[15:8];
   assign rsp.pixel_blue   = color_ff[23:16];
   assign rsp.is_last      = (col_ff == 5'(PANEL_SIZE - 1));
   assign rsp.glyph_total  = count_ff;
   assign rsp.scrolling    = (width_ff > 9'(PANEL_SIZE));
endmodule

// ----- hw/rtl/scrolling_text_column_renderer.sv -----
// A commit reads each character store entry, waits for the registered read, then
// classifies it and writes its glyph, and ends with a layout step. A render first
// takes the scroll step, then for each column reads, waits for and tests glyphs
// up to the owning glyph and reads its color, or tests every glyph when none owns
// the column, then waits for the response to be taken.
// ----------------------------------------------------------------------------
// scrolling_text_column_renderer
// Top level: text layout and scrolling column renderer for a 16x16 panel.
// ----------------------------------------------------------------------------
module scrolling_text_column_renderer #(
   parameter int MAX_CHARS  = stcr_pkg::MAX_CHARS_DEF,
   parameter int PANEL_SIZE = stcr_pkg::PANEL_SIZE_DEF
) (
   input logic clock,
   input logic reset,
   stcr_req_if.sink   req,
   stcr_rsp_if.source rsp,
   stcr_csr_if.sink   csr
);
   stcr_ctrl #(.MAX_CHARS(MAX_CHARS), .PANEL_SIZE(PANEL_SIZE)) u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));
endmodule

// ----- hw/rtl/stcr_checker.sv -----
// ----------------------------------------------------------------------------
// stcr_checker
// Port-level checks of the renderer's channels.
// ----------------------------------------------------------------------------
`include "scrolling_text_column_renderer_macros.svh"
module stcr_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [3:0] rsp_column_index,
   input logic rsp_is_last
);
   `STCR_ASSERT_IMPL(a_no_req_during_rsp, clock, reset, rsp_valid, !req_ready, "request taken while response pending")
   `STCR_ASSERT_IMPL(a_last_col, clock, reset, rsp_valid, rsp_is_last == (rsp_column_index == 4'd15), "is_last mismatch")
   `STCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_column_index), "response dropped")
endmodule

bind scrolling_text_column_renderer stcr_checker u_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_column_index(rsp.column_index),
   .rsp_is_last(rsp.is_last));

// ----- verif/stcr_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stcr_tb_if
// Expected column record shared by the testbench scoreboard.
// ----------------------------------------------------------------------------
// The block's interfaces come from the RTL; this file holds the small helper
// type that carries one expected column result through the scoreboard.
package stcr_tb_pkg;
   typedef struct packed {
      logic [15:0] column_bits;
      logic [3:0]  column_index;
      logic [7:0]  pixel_red;
      logic [7:0]  pixel_green;
      logic [7:0]  pixel_blue;
      logic        is_last;
      logic [6:0]  glyph_total;
      logic        scrolling;
   } column_type;
endpackage

// ----- verif/tb_scrolling_text_column_renderer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scrolling_text_column_renderer
// Drives writes, commits, ticks and renders with random stalls on both
// channels and checks every column against a behavioral panel model.
// ----------------------------------------------------------------------------
import stcr_pkg::*;
import stcr_tb_pkg::*;

class column_scoreboard;
   bit          spacing;
   logic [8:0]  interval;
   logic [31:0] chars [64];
   logic [5:0]  g_font [64];
   logic [5:0]  g_pos [64];
   int          g_x [64];
   int          g_w [64];
   int          count;
   int          width;
   int          offset;
   int          elapsed;
   column_type  pending [$];
   int          errors;
   int          columns_seen;

   function new();
      spacing = 0;
      interval = 200;
      count = 0;
      width = 0;
      offset = 0;
      elapsed = 0;
      errors = 0;
      columns_seen = 0;
   endfunction

   function void set_csr(logic idx, logic [8:0] val);
      if (idx == CSR_SPACING) spacing = val[0];
      else interval = val;
   endfunction

   // Cell widths and pixels follow the panel font, rebuilt here as tables.
   function int glyph_w(int f);
      int wide4 [] = '{10, 11, 12, 13, 16, 17, 20, 24, 30};
      int wide5 [] = '{22, 23, 26, 31, 32, 33, 35};
      foreach (wide4[k]) if (wide4[k] == f) return 4;
      foreach (wide5[k]) if (wide5[k] == f) return 5;
      return 3;
   endfunction

   function logic [15:0] glyph_col(int f, int c);
      logic [15:0] t [36][5] = '{
         '{16'h7FFE,16'h6006,16'h7FFE,0,0}, '{16'h6018,16'h7FFE,16'h6000,0,0},
         '{16'h7F86,16'h6186,16'h61FE,0,0}, '{16'h6186,16'h6186,16'h7FFE,0,0},
         '{16'h01FE,16'h0180,16'h7FFE,0,0}, '{16'h61FE,16'h6186,16'h7F86,0,0},
         '{16'h7FFE,16'h6186,16'h7F86,0,0}, '{16'h0006,16'h0006,16'h7FFE,0,0},
         '{16'h7FFE,16'h6186,16'h7FFE,0,0}, '{16'h01FE,16'h0186,16'h7FFE,0,0},
         '{16'h7FF8,16'h00C6,16'h00C6,16'h7FF8,0},
         '{16'h7FFE,16'h60C6,16'h60C6,16'h1F38,0},
         '{16'h3FFC,16'h6006,16'h6006,16'h381C,0},
         '{16'h7FFE,16'h6006,16'h6006,16'h1FF8,0},
         '{16'h7FFE,16'h6186,16'h6186,0,0}, '{16'h7FFE,16'h0186,16'h0186,0,0},
         '{16'h3FFC,16'h6006,16'h6306,16'h7F1C,0},
         '{16'h7FFE,16'h0180,16'h0180,16'h7FFE,0},
         '{16'h6006,16'h7FFE,16'h6006,0,0}, '{16'h3C00,16'h6000,16'h3FFE,0,0},
         '{16'h7FFE,16'h03C0,16'h0E70,16'h781E,0},
         '{16'h7FFE,16'h6000,16'h6000,0,0},
         '{16'h7FFE,16'h0038,16'h00E0,16'h0038,16'h7FFE},
         '{16'h7FFE,16'h0078,16'h03C0,16'h1E00,16'h7FFE},
         '{16'h1FF8,16'h6006,16'h6006,16'h1FF8,0},
         '{16'h7FFE,16'h0186,16'h00FC,0,0},
         '{16'h1FF8,16'h6006,16'h6606,16'h1FF8,16'h6000},
         '{16'h7FFE,16'h0186,16'h7EFC,0,0}, '{16'h30FC,16'h6186,16'h3F0C,0,0},
         '{16'h0006,16'h7FFE,16'h0006,0,0},
         '{16'h1FFE,16'h6000,16'h6000,16'h1FFE,0},
         '{16'h07FE,16'h1800,16'h7000,16'h1800,16'h07FE},
         '{16'h7FFE,16'h1C00,16'h0700,16'h1C00,16'h7FFE},
         '{16'h781E,16'h0F78,16'h03E0,16'h0F78,16'h781E},
         '{16'h007E,16'h7F80,16'h007E,0,0},
         '{16'h7006,16'h6E06,16'h6186,16'h6076,16'h600E}};
      return t[f][c];
   endfunction

   function void note_request(req_kind_type kind, logic [5:0] pos, logic [7:0] ch,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [6:0] len);
      int cursor;
      int n;
      int lim;
      int c;
      int f;
      int w;
      int x;
      logic [7:0] a;
      column_type e;
      case (kind)
         REQ_WRITE: chars[pos] = {b, g, r, ch};
         REQ_TICK: if (elapsed < 65535) elapsed++;
         REQ_COMMIT: begin
            lim = (len > 64) ? 64 : len;
            cursor = 0;
            n = 0;
            for (int i = 0; i < lim; i++) begin
               a = chars[i][7:0];
               if (a >= "a" && a <= "z") a = a - 8'h20;
               if (a >= "0" && a <= "9") begin
                  f = a - "0";
                  w = glyph_w(f);
               end else if (a >= "A" && a <= "Z") begin
                  f = a - "A" + 10;
                  w = glyph_w(f);
               end else if (a == " ") begin
                  f = 63;
                  w = spacing ? 2 : 1;
               end else continue;
               g_font[n] = 6'(f);
               g_pos[n] = 6'(i);
               g_x[n] = cursor;
               g_w[n] = w;
               cursor += w;
               if (spacing && i + 1 < lim) cursor++;
               n++;
            end
            count = n;
            width = cursor;
            offset = (width > 16) ? 16 : (16 - width) / 2;
            elapsed = 0;
         end
         default: begin
            if (width > 16 && elapsed >= interval) begin
               elapsed = 0;
               offset--;
               if (offset <= -width) offset = 16;
            end
            for (c = 0; c < 16; c++) begin
               x = c - offset;
               e = '0;
               for (int i = 0; i < count; i++) begin
                  if (x >= g_x[i] && x < g_x[i] + g_w[i]) begin
                     if (g_font[i] < 36 && x - g_x[i] < 5)
                        e.column_bits = glyph_col(g_font[i], x - g_x[i]);
                     if (e.column_bits != 0)
                        {e.pixel_blue, e.pixel_green, e.pixel_red} =
                           chars[g_pos[i]][31:8];
                     break;
                  end
               end
               e.column_index = 4'(c);
               e.is_last = (c == 15);
               e.glyph_total = 7'(count);
               e.scrolling = (width > 16);
               pending.push_back(e);
            end
         end
      endcase
   endfunction

   function void check_column(column_type got);
      column_type e;
      columns_seen++;
      if (pending.size() == 0) begin
         $error("unexpected column transaction %p", got);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.column_bits !== e.column_bits) begin
         $error("column_bits exp %h got %h", e.column_bits, got.column_bits); errors++;
      end
      if (got.column_index !== e.column_index) begin
         $error("column_index exp %0d got %0d", e.column_index, got.column_index);
         errors++;
      end
      if (got.pixel_red !== e.pixel_red) begin
         $error("pixel_red exp %h got %h", e.pixel_red, got.pixel_red); errors++;
      end
      if (got.pixel_green !== e.pixel_green) begin
         $error("pixel_green exp %h got %h", e.pixel_green, got.pixel_green); errors++;
      end
      if (got.pixel_blue !== e.pixel_blue) begin
         $error("pixel_blue exp %h got %h", e.pixel_blue, got.pixel_blue); errors++;
      end
      if (got.is_last !== e.is_last) begin
         $error("is_last exp %b got %b", e.is_last, got.is_last); errors++;
      end
      if (got.glyph_total !== e.glyph_total) begin
         $error("glyph_total exp %0d got %0d", e.glyph_total, got.glyph_total); errors++;
      end
      if (got.scrolling !== e.scrolling) begin
         $error("scrolling exp %b got %b", e.scrolling, got.scrolling); errors++;
      end
   endfunction
endclass

module tb_scrolling_text_column_renderer;
   logic clock;
   logic reset;
   int   send_idle;
   int   recv_idle;
   int   cycles;
   int   items;
   int   renders;
   column_scoreboard board;

   stcr_req_if req ();
   stcr_rsp_if rsp ();
   stcr_csr_if csr ();

   scrolling_text_column_renderer dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      req.valid = 0; req.req_type = REQ_WRITE; req.position = 0; req.char_code = 0;
      req.red = 0; req.green = 0; req.blue = 0; req.text_length = 0;
      rsp.ready = 0;
      csr.valid = 0; csr.index = CSR_SPACING; csr.data = 0;
   end

   // Watchdog sized for 16 slow columns per render under heavy stalls.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 900000) begin
         $display("scrolling_text_column_renderer: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         rsp.ready <= ($urandom_range(99) >= recv_idle);
         if (rsp.valid && rsp.ready)
            board.check_column({rsp.column_bits, rsp.column_index, rsp.pixel_red,
                                rsp.pixel_green, rsp.pixel_blue, rsp.is_last,
                                rsp.glyph_total, rsp.scrolling});
      end
   end

   // Each transaction starts on a later clock edge than the one on which the previous
   // one ended, so valid never drops and rises within the same time step.
   task automatic send(req_kind_type kind, logic [5:0] pos, logic [7:0] ch,
                       logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [6:0] len);
      do @(posedge clock); while ($urandom_range(99) < send_idle);
      req.valid <= 1; req.req_type <= kind; req.position <= pos;
      req.char_code <= ch; req.red <= r; req.green <= g; req.blue <= b;
      req.text_length <= len;
      do @(posedge clock); while (!req.ready);
      board.note_request(kind, pos, ch, r, g, b, len);
      req.valid <= 0;
      items++;
      if (kind == REQ_RENDER) renders++;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [8:0] val);
      drain();
      csr.valid <= 1; csr.index <= idx; csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      board.set_csr(idx, val);
      csr.valid <= 0;
   endtask

   task automatic put_char(int pos, logic [7:0] ch);
      send(REQ_WRITE, 6'(pos), ch, 8'($urandom), 8'($urandom), 8'($urandom), 7'd0);
   endtask

   task automatic ticks(int n);
      for (int i = 0; i < n; i++)
         send(REQ_TICK, 6'($urandom), 8'($urandom), 8'd0, 8'd0, 8'd0, 7'($urandom));
   endtask

   // Fills positions with mostly printable text, commits, then scrolls it.
   task automatic random_scene(int len);
      int k;
      logic [7:0] ch;
      for (int i = 0; i < 64; i++) begin
         k = $urandom_range(9);
         ch = (k < 3) ? 8'("A" + $urandom_range(25)) : (k < 5) ? 8'("a" + $urandom_range(25))
            : (k < 7) ? 8'("0" + $urandom_range(9)) : (k < 8) ? 8'(" ") : 8'($urandom);
         put_char(i, ch);
         if (i >= len) break;
      end
      send(REQ_COMMIT, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'(len));
      for (int r = 0; r < 4; r++) begin
         ticks($urandom_range(3));
         send(REQ_RENDER, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 7'($urandom));
      end
   endtask

   task automatic run_random(int n);
      int stop;
      stop = items + n;
      while (items < stop) begin
         if ($urandom_range(4) == 0) write_reg(CSR_SPACING, 9'($urandom_range(1)));
         random_scene($urandom_range(3) == 0 ? $urandom_range(24) : $urandom_range(8));
      end
   endtask

   initial begin
      board = new();
      cycles = 0; items = 0; renders = 0;
      send_idle = 0; recv_idle = 0;
      reset = 1;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: full store, digits, letters, folding, drops and a space.
      put_char(0, "0"); put_char(1, "9"); put_char(2, "a"); put_char(3, "Z");
      put_char(4, 8'hFF); put_char(5, " "); put_char(6, "m");
      for (int i = 7; i < 63; i++) put_char(i, 8'h20);
      send(REQ_WRITE, 6'd63, 8'h00, 8'hFF, 8'h00, 8'hFF, 7'd0);
      send(REQ_COMMIT, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd7);
      send(REQ_RENDER, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0);
      write_reg(CSR_SPACING, 9'd1);
      write_reg(CSR_INTERVAL, 9'd3);
      send(REQ_COMMIT, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd127);
      ticks(3);
      send(REQ_RENDER, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0);
      send(REQ_RENDER, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0);
      // Text ending in dropped codes still keeps its trailing gap.
      put_char(0, "W"); put_char(1, "?"); put_char(2, "!");
      send(REQ_COMMIT, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd3);
      send(REQ_RENDER, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0);
      send(REQ_COMMIT, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0);
      send(REQ_RENDER, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0);
      write_reg(CSR_INTERVAL, 9'd0);
      write_reg(CSR_INTERVAL, 9'h1FF);
      write_reg(CSR_INTERVAL, 9'd300);
      write_reg(CSR_SPACING, 9'd0);

      send_idle = 29; recv_idle = 87;
      run_random(10);
      write_reg(CSR_INTERVAL, 9'd1);
      send_idle = 87; recv_idle = 29;
      run_random(10);
      // Hold off until the output side has caught up completely.
      drain();
      write_reg(CSR_INTERVAL, 9'd2);
      send_idle = 0; recv_idle = 0;
      run_random(10);
      drain();

      $display("Covered %0d transactions, %0d renders, %0d columns checked.",
               items, renders, board.columns_seen);
      $display("Both spacing modes, saturated and empty commits, and scrolling text were exercised.");
      if (board.errors == 0)
         $display("scrolling_text_column_renderer: match");
      else
         $display("scrolling_text_column_renderer: mismatch");
      $finish;
   end
endmodule
